// File: hw/rtl/mwcg_pkg.sv
// mwcg_pkg: shared types and constants for the monotonic wall-clock guard
// status codes, register indexes, register reset values, config and state structs
// no dependencies
`timescale 1ns / 1ps

package mwcg_pkg;

  localparam int unsigned MsW     = 42;
  localparam int unsigned LagW    = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned WallW   = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MsW-1:0]     MinPlausibleRst = 42'd1577836800000;
  localparam logic [MsW-1:0]     MaxPlausibleRst = 42'd4102444800000;
  localparam logic [LagW-1:0]    MaxLagRst       = 32'd1000;
  localparam logic [PeriodW-1:0] TickPeriodRst   = 10'd10;

  typedef enum logic [2:0] {
    StWaiting     = 3'd0,
    StReady       = 3'd1,
    StImplausible = 3'd2,
    StRegressed   = 3'd3,
    StStale       = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinPlausible = 2'd0,
    CfgMaxPlausible = 2'd1,
    CfgMaxLag       = 2'd2,
    CfgTickPeriod   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MsW-1:0]     min_plausible;
    logic [MsW-1:0]     max_plausible;
    logic [LagW-1:0]    max_lag;
    logic [PeriodW-1:0] tick_period;
  } cfg_t;

  typedef struct packed {
    logic               anchored;
    logic [MsW-1:0]     last_proto;
    logic [MsW-1:0]     last_wall;
    logic [TickW-1:0]   last_tick;
  } state_t;

endpackage

// File: hw/rtl/mwcg_eval.sv
// mwcg_eval: classifies one sample against the anchor state and forms the protocol time
// depends on mwcg_pkg
`timescale 1ns / 1ps

module mwcg_eval (
  input  mwcg_pkg::cfg_t                       cfg_i,
  input  mwcg_pkg::state_t                     state_i,
  input  logic                                 sync_confirmed_i,
  input  logic                                 read_ok_i,
  input  logic [mwcg_pkg::WallW-1:0]           wall_ms_i,
  input  logic [mwcg_pkg::TickW-1:0]           mono_tick_i,
  output mwcg_pkg::status_e                    status_o,
  output logic [mwcg_pkg::MsW-1:0]             protocol_ms_o
);

  localparam int unsigned MsW = mwcg_pkg::MsW;

  logic [mwcg_pkg::TickW-1:0] delta;
  logic [MsW-1:0]             advance;
  logic [MsW:0]               expected;
  logic [MsW:0]               wall_ext;
  logic [MsW:0]               lag;
  logic [MsW:0]               proto;
  logic                       below_min;
  logic                       at_or_above_max;
  logic                       regressed;
  logic                       behind;
  logic                       stale;
  logic                       too_big;

  always_comb begin
    delta    = mono_tick_i - state_i.last_tick;
    // 32 x 10 bit product always fits in 42 bits
    advance  = {{(MsW-mwcg_pkg::TickW){1'b0}}, delta}
             * {{(MsW-mwcg_pkg::PeriodW){1'b0}}, cfg_i.tick_period};
    expected = {1'b0, state_i.last_proto} + {1'b0, advance};

    below_min       = wall_ms_i < {{(mwcg_pkg::WallW-MsW){1'b0}}, cfg_i.min_plausible};
    at_or_above_max = wall_ms_i >= {{(mwcg_pkg::WallW-MsW){1'b0}}, cfg_i.max_plausible};
    regressed       = state_i.anchored &&
                      (wall_ms_i < {{(mwcg_pkg::WallW-MsW){1'b0}}, state_i.last_wall});

    // wall is inside the plausible window here, so its low bits carry it
    wall_ext = {1'b0, wall_ms_i[MsW-1:0]};
    behind   = wall_ext < expected;
    lag      = expected - wall_ext;
    stale    = state_i.anchored && behind &&
               (lag > {{(MsW+1-mwcg_pkg::LagW){1'b0}}, cfg_i.max_lag});

    proto   = (state_i.anchored && behind) ? expected : wall_ext;
    too_big = proto >= {1'b0, cfg_i.max_plausible};

    priority if (!sync_confirmed_i || !read_ok_i) begin
      status_o = mwcg_pkg::StWaiting;
    end else if (below_min || at_or_above_max) begin
      status_o = mwcg_pkg::StImplausible;
    end else if (regressed) begin
      status_o = mwcg_pkg::StRegressed;
    end else if (stale) begin
      status_o = mwcg_pkg::StStale;
    end else if (too_big) begin
      status_o = mwcg_pkg::StImplausible;
    end else begin
      status_o = mwcg_pkg::StReady;
    end

    protocol_ms_o = (status_o == mwcg_pkg::StReady) ? proto[MsW-1:0] : '0;
  end

endmodule

// File: hw/rtl/monotonic_wall_clock_guard.sv
// monotonic_wall_clock_guard: top level with input register, evaluation, result register
// depends on mwcg_pkg and mwcg_eval
`timescale 1ns / 1ps

// Takes one sample beat per clock unless the input is stalled and presents one result beat
// per sample from the result register, holding it while the output is stalled. A sample sits in the
// input register while the tick-delta multiply, the add and the window and lag compares
// resolve; the result register and the anchor state are loaded together as the sample
// leaves it, so the next sample is judged against the updated anchor. The multiply-add-compare
// path between the two registers sets the clock. Configuration writes take effect on the next
// cycle and are meant to be made while no sample is in flight.

module monotonic_wall_clock_guard (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mwcg_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [mwcg_pkg::MsW-1:0]             cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 sync_confirmed_i,
  input  logic                                 read_ok_i,
  input  logic [mwcg_pkg::WallW-1:0]           wall_ms_i,
  input  logic [mwcg_pkg::TickW-1:0]           mono_tick_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic [mwcg_pkg::MsW-1:0]             protocol_ms_o
);

  localparam int unsigned MsW = mwcg_pkg::MsW;

  mwcg_pkg::cfg_t   cfg_q;
  mwcg_pkg::state_t state_q, state_d;

  logic                        s1_valid_q;
  logic                        s1_sync_q;
  logic                        s1_ok_q;
  logic [mwcg_pkg::WallW-1:0]  s1_wall_q;
  logic [mwcg_pkg::TickW-1:0]  s1_tick_q;

  logic                        out_valid_q;
  mwcg_pkg::status_e           out_status_q;
  logic [MsW-1:0]              out_proto_q;

  mwcg_pkg::status_e           res_status;
  logic [MsW-1:0]              res_proto;
  logic                        advance;
  logic                        process;
  logic                        in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_plausible <= mwcg_pkg::MinPlausibleRst;
      cfg_q.max_plausible <= mwcg_pkg::MaxPlausibleRst;
      cfg_q.max_lag       <= mwcg_pkg::MaxLagRst;
      cfg_q.tick_period   <= mwcg_pkg::TickPeriodRst;
    end else if (cfg_we_i) begin
      unique case (mwcg_pkg::cfg_idx_e'(cfg_idx_i))
        mwcg_pkg::CfgMinPlausible: cfg_q.min_plausible <= cfg_wdata_i;
        mwcg_pkg::CfgMaxPlausible: cfg_q.max_plausible <= cfg_wdata_i;
        mwcg_pkg::CfgMaxLag:       cfg_q.max_lag <= cfg_wdata_i[mwcg_pkg::LagW-1:0];
        mwcg_pkg::CfgTickPeriod:   cfg_q.tick_period <= cfg_wdata_i[mwcg_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sync_q <= sync_confirmed_i;
      s1_ok_q   <= read_ok_i;
      s1_wall_q <= wall_ms_i;
      s1_tick_q <= mono_tick_i;
    end
  end

  mwcg_eval u_eval (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .sync_confirmed_i (s1_sync_q),
    .read_ok_i        (s1_ok_q),
    .wall_ms_i        (s1_wall_q),
    .mono_tick_i      (s1_tick_q),
    .status_o         (res_status),
    .protocol_ms_o    (res_proto)
  );

  // anchor state, updated only by a ready beat
  always_comb begin
    state_d = state_q;
    if (process && (res_status == mwcg_pkg::StReady)) begin
      state_d.anchored   = 1'b1;
      state_d.last_proto = res_proto;
      state_d.last_wall  = s1_wall_q[MsW-1:0];
      state_d.last_tick  = s1_tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_status_q <= res_status;
      out_proto_q  <= res_proto;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign protocol_ms_o = out_proto_q;

  // checks
  a_zero_unless_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != mwcg_pkg::StReady)) |-> (out_proto_q == '0))
    else $error("non-ready result carries a nonzero time");

  a_ready_anchors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && (res_status == mwcg_pkg::StReady)) |=> state_q.anchored)
    else $error("ready beat did not anchor the state");

  a_hold_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && (res_status != mwcg_pkg::StReady)) |=>
      ($stable(state_q.last_proto) && $stable(state_q.last_tick)))
    else $error("rejected beat changed the anchor state");

  a_proto_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && (res_status == mwcg_pkg::StReady)) |=>
      (state_q.last_proto >= $past(state_q.last_proto)))
    else $error("protocol time went backwards");

endmodule

// File: bench/mwcg_checker.sv
// mwcg_checker: predicts each result beat of the monotonic wall-clock guard and compares it
// keeps its own register and anchor copies, an in-order store of expected results, a fail count
// depends on mwcg_pkg
`timescale 1ns / 1ps

module mwcg_checker import mwcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               sync_confirmed_i,
  input  logic               read_ok_i,
  input  logic [WallW-1:0]   wall_ms_i,
  input  logic [TickW-1:0]   mono_tick_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic [MsW-1:0]     protocol_ms_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);

  typedef struct packed {
    status_e        status;
    logic [MsW-1:0] ms;
  } verdict_t;

  logic [MsW-1:0]     lim_min;
  logic [MsW-1:0]     lim_max;
  logic [LagW-1:0]    lag_limit;
  logic [PeriodW-1:0] ms_per_tick;

  logic               gate_anchored;
  logic [MsW-1:0]     anchor_proto;
  logic [MsW-1:0]     anchor_wall;
  logic [TickW-1:0]   anchor_tick;

  verdict_t verdicts_q[$];
  verdict_t want;
  int       mismatches = 0;
  int       open_count = 0;
  int       results_seen = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = open_count;

  function automatic verdict_t judge_sample(input logic sync, input logic ok,
                                            input logic [WallW-1:0] wall,
                                            input logic [TickW-1:0] tick);
    verdict_t         v;
    logic [TickW-1:0] delta;
    logic [63:0]      expected;
    logic [63:0]      proto;
    v.status = StWaiting;
    v.ms     = '0;
    if (!sync || !ok) return v;
    if (wall < 64'(lim_min) || wall >= 64'(lim_max)) begin
      v.status = StImplausible;
      return v;
    end
    if (gate_anchored && wall < 64'(anchor_wall)) begin
      v.status = StRegressed;
      return v;
    end
    proto = wall;
    if (gate_anchored) begin
      delta    = tick - anchor_tick;
      expected = 64'(anchor_proto) + 64'(delta) * 64'(ms_per_tick);
      if (wall < expected && expected - wall > 64'(lag_limit)) begin
        v.status = StStale;
        return v;
      end
      if (expected > proto) proto = expected;
    end
    if (proto >= 64'(lim_max)) begin
      v.status = StImplausible;
      return v;
    end
    gate_anchored = 1'b1;
    anchor_proto  = proto[MsW-1:0];
    anchor_wall   = wall[MsW-1:0];
    anchor_tick   = tick;
    v.status      = StReady;
    v.ms          = proto[MsW-1:0];
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("error: result beat %0d: %s", results_seen, what);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_min       = MinPlausibleRst;
      lim_max       = MaxPlausibleRst;
      lag_limit     = MaxLagRst;
      ms_per_tick   = TickPeriodRst;
      gate_anchored = 1'b0;
      anchor_proto  = '0;
      anchor_wall   = '0;
      anchor_tick   = '0;
      verdicts_q.delete();
      open_count    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgMinPlausible: lim_min = cfg_wdata_i;
          CfgMaxPlausible: lim_max = cfg_wdata_i;
          CfgMaxLag:       lag_limit = cfg_wdata_i[LagW-1:0];
          CfgTickPeriod:   ms_per_tick = cfg_wdata_i[PeriodW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen = results_seen + 1;
        if (verdicts_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = verdicts_q.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
          if (protocol_ms_i !== want.ms)
            report_mismatch($sformatf("protocol_ms got %0d want %0d", protocol_ms_i, want.ms));
        end
      end
      if (in_valid_i && !in_stall_i)
        verdicts_q.push_back(judge_sample(sync_confirmed_i, read_ok_i, wall_ms_i, mono_tick_i));
      open_count = verdicts_q.size();
    end
  end

endmodule

// File: bench/monotonic_wall_clock_guard_tb.sv
// monotonic_wall_clock_guard_tb: drives samples and register writes into the guard, stalls results
// a directed opening, then phases of random sample streams under varied register settings
// depends on mwcg_pkg, monotonic_wall_clock_guard and mwcg_checker
`timescale 1ns / 1ps

module monotonic_wall_clock_guard_tb;
  import mwcg_pkg::*;

  localparam int          IdleLimit = 2000;
  localparam logic [63:0] MinMs     = 64'(MinPlausibleRst);
  localparam logic [63:0] MaxMs     = 64'(MaxPlausibleRst);
  localparam logic [63:0] AnchorMs  = MinMs + 64'd100000;
  localparam logic [MsW-1:0] MsTop  = '1;
  localparam logic [MsW-1:0] MsHalf = 42'h200_0000_0000;
  localparam logic [MsW-1:0] TeraMs = 42'd1000000000000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_idx_e           cfg_idx = CfgMinPlausible;
  logic [MsW-1:0]     cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic               sync_confirmed = 1'b0;
  logic               read_ok = 1'b0;
  logic [WallW-1:0]   wall_ms = '0;
  logic [TickW-1:0]   mono_tick = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [2:0]         status_o;
  logic [MsW-1:0]     protocol_ms_o;

  int                 fail_count;
  int                 outstanding;
  int                 stuck_cycles = 0;
  bit                 quiet = 1'b0;
  logic [63:0]        gen_t = '0;
  logic [TickW-1:0]   gen_tick = '0;

  monotonic_wall_clock_guard i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .sync_confirmed_i(sync_confirmed),
    .read_ok_i       (read_ok),
    .wall_ms_i       (wall_ms),
    .mono_tick_i     (mono_tick),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .protocol_ms_o   (protocol_ms_o)
  );

  mwcg_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .sync_confirmed_i(sync_confirmed),
    .read_ok_i       (read_ok),
    .wall_ms_i       (wall_ms),
    .mono_tick_i     (mono_tick),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_i        (status_o),
    .protocol_ms_i   (protocol_ms_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic send_sample(input logic s, input logic ok, input logic [WallW-1:0] wall,
                             input logic [TickW-1:0] tick);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    sync_confirmed <= s;
    read_ok        <= ok;
    wall_ms        <= wall;
    mono_tick      <= tick;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [MsW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [MsW-1:0] lo, input logic [MsW-1:0] hi,
                           input logic [LagW-1:0] lag, input logic [PeriodW-1:0] period,
                           input int count, input bit no_gaps, input bit leap);
    int unsigned      kind;
    int unsigned      delta;
    int unsigned      rate;
    int unsigned      jneg;
    int unsigned      pick;
    logic [TickW-1:0] jump;
    logic [63:0]      wall;
    settle();
    write_reg(CfgMinPlausible, lo);
    write_reg(CfgMaxPlausible, hi);
    write_reg(CfgMaxLag, MsW'(lag));
    write_reg(CfgTickPeriod, MsW'(period));
    quiet = no_gaps;
    rate  = (period == 0) ? 10 : period;
    jneg  = (lag > 2000) ? 4000 : 2 * lag + 2;
    // tick jumps to just below wrap so the stream wraps within the phase
    if (leap) begin
      jump     = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      gen_t    = gen_t + 64'(jump - gen_tick) * rate;
      gen_tick = jump;
      send_sample(1'b1, 1'b1, gen_t, gen_tick);
    end
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        delta    = $urandom_range(0, 200);
        gen_tick = gen_tick + delta;
        gen_t    = gen_t + 64'(delta) * rate;
        wall     = gen_t - $urandom_range(0, jneg);
        if ($urandom_range(0, 1)) wall = wall + $urandom_range(0, 1000);
        send_sample(1'b1, 1'b1, wall, gen_tick);
      end else if (kind < 80) begin
        pick = $urandom_range(0, 2);
        send_sample(pick[1], pick[0], {$urandom, $urandom}, $urandom);
      end else if (kind < 88) begin
        if (lo > 1000 && $urandom_range(0, 1)) wall = 64'(lo) - 1 - $urandom_range(0, 999);
        else wall = {$urandom, $urandom} | (64'd1 << MsW);
        send_sample(1'b1, 1'b1, wall, $urandom);
      end else if (kind < 94) begin
        send_sample(1'b1, 1'b1, 64'(lo) + $urandom_range(0, 1000), $urandom);
      end else begin
        // backwards tick with a sample just ahead of the stream
        pick = $urandom_range(0, 3);
        send_sample(pick[1], pick[0], gen_t + $urandom_range(0, 2000),
                    gen_tick - $urandom_range(1, 1000));
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed opening under reset register values
    send_sample(1'b0, 1'b1, MinMs, 32'd0);
    send_sample(1'b1, 1'b0, MinMs, 32'd0);
    send_sample(1'b0, 1'b0, '1, '1);
    send_sample(1'b1, 1'b1, 64'd0, 32'd0);
    send_sample(1'b1, 1'b1, '1, 32'h5555_5555);
    send_sample(1'b1, 1'b1, MaxMs, 32'd0);
    send_sample(1'b1, 1'b1, MinMs - 1, 32'd0);
    send_sample(1'b1, 1'b1, 64'd1 << MsW, 32'd0);
    send_sample(1'b1, 1'b1, AnchorMs, 32'hFFFF_FFF0);
    send_sample(1'b1, 1'b1, AnchorMs - 50000, 32'hAAAA_AAAA);
    send_sample(1'b1, 1'b1, AnchorMs + 320, 32'h10);
    send_sample(1'b1, 1'b1, AnchorMs + 320 + 10000 - 1001, 32'h3F8);
    send_sample(1'b1, 1'b1, AnchorMs + 320 + 10000 - 1000, 32'h3F8);
    send_sample(1'b1, 1'b1, AnchorMs + 16320, 32'h45C);
    send_sample(1'b1, 1'b1, AnchorMs + 16320, 32'h45C);
    send_sample(1'b1, 1'b1, AnchorMs + 16320, 32'h45B);
    send_sample(1'b1, 1'b1, MaxMs - 2000, 32'h45C);
    send_sample(1'b1, 1'b1, MaxMs - 1, 32'h556);
    send_sample(1'b1, 1'b1, MaxMs - 600, 32'h4F2);
    gen_t    = MaxMs - 500;
    gen_tick = 32'h4F2;

    run_phase(42'd0, MsTop, 32'd1000, 10'd10, 150, 1'b1, 1'b1);
    run_phase(42'd0, MsTop, 32'd1000, 10'd10, 150, 1'b0, 1'b0);
    run_phase(42'd0, MsTop, 32'd0, 10'd1, 150, 1'b0, 1'b1);
    run_phase(42'd0, MsTop, 32'd50, 10'd0, 150, 1'b0, 1'b1);
    run_phase(MsTop, 42'd0, 32'd1000, 10'd10, 25, 1'b0, 1'b0);
    run_phase(MsHalf, MsHalf, 32'd1000, 10'd10, 25, 1'b0, 1'b0);
    run_phase(42'd0, MsTop, 32'hFFFF_FFFF, 10'd1000, 200, 1'b0, 1'b0);
    run_phase(TeraMs, MsTop, 32'd5000, 10'd1023, 150, 1'b0, 1'b0);
    run_phase(42'd0, MsTop, 32'd1000, 10'd10, 200, 1'b0, 1'b1);

    settle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mwcg_pkg.sv
hw/rtl/mwcg_eval.sv
hw/rtl/monotonic_wall_clock_guard.sv
bench/mwcg_checker.sv
bench/monotonic_wall_clock_guard_tb.sv
